FILE: hdl/mpmt_pkg.sv
// ----------------------------------------------------------------------------
// mpmt_pkg
// Shared types and constants of the multi-pattern stream matcher.
// ----------------------------------------------------------------------------
package mpmt_pkg;

    localparam int NUM_PAT         = 3;
    localparam int MAX_PATTERN_LEN = 8;
    localparam int CAPTURE_DEPTH   = 1024;

    localparam int PAT_IDX_W = 2;
    localparam int PLEN_W    = 4;
    localparam int POS_W     = 10;
    localparam int CAP_W     = 11;
    localparam int TICK_W    = 32;
    localparam int CHARS_W   = 64;
    localparam int LENS_W    = 12;
    localparam int LIMIT_W   = 10;

    localparam int PDATA_W = 64;
    localparam int PADDR_W = 6;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_RECV     = 3'd1,
        ST_FIRST    = 3'd2,
        ST_ALL      = 3'd3,
        ST_TIMEOUT  = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        REG_PAT_A     = 3'd0,
        REG_PAT_B     = 3'd1,
        REG_PAT_C     = 3'd2,
        REG_LENGTHS   = 3'd3,
        REG_COUNT     = 3'd4,
        REG_MODE      = 3'd5,
        REG_TIMEOUT   = 3'd6,
        REG_CAP_LIMIT = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_PAT-1:0][CHARS_W-1:0] chars;
        logic [LENS_W-1:0]               lengths;
        logic [1:0]                      count;
        logic                            mode;
        logic [TICK_W-1:0]               timeout;
        logic [LIMIT_W-1:0]              limit;
    } t_cfg;

endpackage

FILE: hdl/mpmt_if.sv
// ----------------------------------------------------------------------------
// mpmt stream interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface mpmt_in_if;
    import mpmt_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface mpmt_out_if;
    import mpmt_pkg::*;

    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [POS_W-1:0] byte_position;
    logic [1:0]       matched_pattern;
    logic [POS_W-1:0] match_start;

    modport source (output valid, output status, output byte_position,
                    output matched_pattern, output match_start, input ready);
    modport sink   (input valid, input status, input byte_position,
                    input matched_pattern, input match_start, output ready);
endinterface

FILE: hdl/mpmt_regs.sv
// ----------------------------------------------------------------------------
// mpmt_regs
// APB register file holding the pattern, length, count, mode, timeout and limit settings.
// ----------------------------------------------------------------------------
module mpmt_regs
    import mpmt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:3]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_PAT_A:     n_cfg.chars[0] = pwdata;
                REG_PAT_B:     n_cfg.chars[1] = pwdata;
                REG_PAT_C:     n_cfg.chars[2] = pwdata;
                REG_LENGTHS:   n_cfg.lengths  = pwdata[LENS_W-1:0];
                REG_COUNT:     n_cfg.count    = pwdata[1:0];
                REG_MODE:      n_cfg.mode     = pwdata[0];
                REG_TIMEOUT:   n_cfg.timeout  = pwdata[TICK_W-1:0];
                REG_CAP_LIMIT: n_cfg.limit    = pwdata[LIMIT_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_PAT_A:     prdata = r_cfg.chars[0];
            REG_PAT_B:     prdata = r_cfg.chars[1];
            REG_PAT_C:     prdata = r_cfg.chars[2];
            REG_LENGTHS:   prdata = PDATA_W'(r_cfg.lengths);
            REG_COUNT:     prdata = PDATA_W'(r_cfg.count);
            REG_MODE:      prdata = PDATA_W'(r_cfg.mode);
            REG_TIMEOUT:   prdata = PDATA_W'(r_cfg.timeout);
            REG_CAP_LIMIT: prdata = PDATA_W'(r_cfg.limit);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chars   <= '0;
            r_cfg.lengths <= LENS_W'(12'h111);
            r_cfg.count   <= 2'd1;
            r_cfg.mode    <= 1'b0;
            r_cfg.timeout <= TICK_W'(1000);
            r_cfg.limit   <= LIMIT_W'(99);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: hdl/multi_pattern_match_timeout.sv
// ----------------------------------------------------------------------------
// multi_pattern_match_timeout
// Watches a byte stream for up to three patterns, with byte limit and timeout.
//
//   channel  | dir | handshake       | word
//   i_in     | in  | valid/ready     | opcode, data_byte
//   o_out    | out | valid/ready     | status, byte_position, matched_pattern,
//            |     |                 | match_start
//   APB      | in  | psel/penable    | 64-bit registers at 8*index
//
// One word per cycle while the result channel is not stalled; each word
// sits in the input register and leaves through the result register.
// All pattern compares run in parallel in the single stage between them.
// Synchronous active-low reset clears the run state and the valid bits of both registers.
// A stalled result holds; the input register still takes a word while the
// result waits, then holds until the result moves.
// ----------------------------------------------------------------------------
module multi_pattern_match_timeout
    import mpmt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    mpmt_in_if.sink            i_in,
    mpmt_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg w_cfg;

    mpmt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input register
    logic       r_in_valid;
    t_opcode    r_op;
    logic [7:0] r_byte;

    // run state
    logic                             r_run,    n_run;
    logic [NUM_PAT-1:0][PLEN_W-1:0]   r_ppos,   n_ppos;
    logic [NUM_PAT-1:0][POS_W-1:0]    r_pstart, n_pstart;
    logic [NUM_PAT-1:0]               r_pdone,  n_pdone;
    logic [POS_W-1:0]                 r_cap,    n_cap;
    logic [TICK_W-1:0]                r_tick,   n_tick;

    // result register
    logic             r_out_valid;
    t_status          r_status,  n_status;
    logic [POS_W-1:0] r_bpos,    n_bpos;
    logic [1:0]       r_mpat,    n_mpat;
    logic [POS_W-1:0] r_mstart,  n_mstart;

    logic w_adv;
    logic w_in_take;

    logic [PAT_IDX_W-1:0]           w_used;
    logic [NUM_PAT-1:0]             w_use;
    logic [NUM_PAT-1:0][PLEN_W-1:0] w_len;
    logic [NUM_PAT-1:0][7:0]        w_char;
    logic [NUM_PAT-1:0]             w_hit;
    logic [NUM_PAT-1:0]             w_comp;
    logic                           w_found;
    logic [1:0]                     w_fpat;
    logic [POS_W-1:0]               w_fstart;
    logic [CAP_W-1:0]               w_limit;
    logic                           w_ovf;
    logic                           w_all;

    assign w_adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_take = i_in.valid && i_in.ready;

    assign w_used  = (32'(w_cfg.count) > NUM_PAT) ? PAT_IDX_W'(NUM_PAT) : w_cfg.count;
    assign w_limit = (32'(w_cfg.limit) > CAPTURE_DEPTH) ? CAP_W'(CAPTURE_DEPTH)
                                                        : CAP_W'(w_cfg.limit);
    assign w_ovf   = (CAP_W'(r_cap) + CAP_W'(1)) > w_limit;

    // per-pattern compare
    always_comb begin
        for (int i = 0; i < NUM_PAT; i++) begin
            w_use[i]  = (32'(w_used) > i);
            w_len[i]  = (32'(w_cfg.lengths[PLEN_W*i +: PLEN_W]) > MAX_PATTERN_LEN)
                        ? PLEN_W'(MAX_PATTERN_LEN) : w_cfg.lengths[PLEN_W*i +: PLEN_W];
            w_char[i] = w_cfg.chars[i][8*r_ppos[i][2:0] +: 8];
            w_hit[i]  = w_use[i] && !r_pdone[i] && (w_len[i] != '0) &&
                        (r_ppos[i] < w_len[i]) && (w_char[i] == r_byte);
            w_comp[i] = w_hit[i] && ((r_ppos[i] + PLEN_W'(1)) == w_len[i]);
        end
    end

    // lowest completing pattern wins
    always_comb begin
        w_found  = 1'b0;
        w_fpat   = '0;
        w_fstart = '0;
        for (int i = NUM_PAT - 1; i >= 0; i--) begin
            if (w_comp[i]) begin
                w_found  = 1'b1;
                w_fpat   = 2'(i);
                w_fstart = (r_ppos[i] == '0) ? r_cap : r_pstart[i];
            end
        end
    end

    always_comb begin
        n_run    = r_run;
        n_ppos   = r_ppos;
        n_pstart = r_pstart;
        n_pdone  = r_pdone;
        n_cap    = r_cap;
        n_tick   = r_tick;
        n_status = ST_IDLE;
        n_bpos   = '0;
        n_mpat   = '0;
        n_mstart = '0;
        w_all    = 1'b1;

        for (int i = 0; i < NUM_PAT; i++) begin
            if (w_hit[i]) begin
                w_all = w_all && (!w_use[i] || w_comp[i] || r_pdone[i]);
            end else begin
                w_all = w_all && (!w_use[i] || r_pdone[i]);
            end
        end

        unique case (r_op)
            OP_START: begin
                n_run    = 1'b1;
                n_ppos   = '0;
                n_pstart = '0;
                n_pdone  = '0;
                n_cap    = '0;
                n_tick   = '0;
                n_status = ST_RECV;
            end
            OP_TICK: begin
                if (r_run) begin
                    if ((33'(r_tick) + 33'd1) >= 33'(w_cfg.timeout)) begin
                        n_tick   = w_cfg.timeout;
                        n_run    = 1'b0;
                        n_status = ST_TIMEOUT;
                    end else begin
                        n_tick   = r_tick + TICK_W'(1);
                        n_status = ST_RECV;
                    end
                end
            end
            OP_BYTE: begin
                if (r_run) begin
                    n_bpos = r_cap;
                    if (w_ovf) begin
                        n_run    = 1'b0;
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_cap = r_cap + POS_W'(1);
                        for (int i = 0; i < NUM_PAT; i++) begin
                            if (w_use[i] && !r_pdone[i]) begin
                                if (w_hit[i]) begin
                                    if (r_ppos[i] == '0) begin
                                        n_pstart[i] = r_cap;
                                    end
                                    n_ppos[i]  = r_ppos[i] + PLEN_W'(1);
                                    n_pdone[i] = w_comp[i];
                                end else begin
                                    n_ppos[i]   = '0;
                                    n_pstart[i] = '0;
                                end
                            end
                        end
                        n_mpat   = w_fpat;
                        n_mstart = w_fstart;
                        if (!w_cfg.mode && w_found) begin
                            n_run    = 1'b0;
                            n_status = ST_FIRST;
                        end else if (w_all) begin
                            n_run    = 1'b0;
                            n_status = ST_ALL;
                        end else begin
                            n_status = ST_RECV;
                        end
                    end
                end
            end
            default: begin
                n_status = r_run ? ST_RECV : ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_run       <= 1'b0;
            r_ppos      <= '0;
            r_pstart    <= '0;
            r_pdone     <= '0;
            r_cap       <= '0;
            r_tick      <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_run       <= n_run;
                r_ppos      <= n_ppos;
                r_pstart    <= n_pstart;
                r_pdone     <= n_pdone;
                r_cap       <= n_cap;
                r_tick      <= n_tick;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op   <= t_opcode'(i_in.opcode);
            r_byte <= i_in.data_byte;
        end
        if (w_adv) begin
            r_status <= n_status;
            r_bpos   <= n_bpos;
            r_mpat   <= n_mpat;
            r_mstart <= n_mstart;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.byte_position   = r_bpos;
    assign o_out.matched_pattern = r_mpat;
    assign o_out.match_start     = r_mstart;

endmodule

FILE: hdl/mpmt_checker.sv
// ----------------------------------------------------------------------------
// mpmt_checker
// Port-level checks on the result channel of the stream matcher.
// ----------------------------------------------------------------------------
module mpmt_checker
    import mpmt_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic [2:0]       i_status,
    input logic [POS_W-1:0] i_bpos,
    input logic [1:0]       i_mpat,
    input logic [POS_W-1:0] i_mstart
);

    // hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_bpos))
        else $error("result word dropped or changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_status <= ST_OVERFLOW)
        else $error("status code out of range");

    a_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_IDLE || i_status == ST_TIMEOUT) |->
            i_bpos == '0 && i_mpat == '0 && i_mstart == '0)
        else $error("non-byte word carries byte fields");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_mstart <= i_bpos)
        else $error("match start lies after the byte that completed it");

    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_OVERFLOW |-> i_mpat == '0 && i_mstart == '0)
        else $error("overflow word reports a match");

endmodule

bind multi_pattern_match_timeout mpmt_checker u_mpmt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_status (o_out.status),
    .i_bpos   (o_out.byte_position),
    .i_mpat   (o_out.matched_pattern),
    .i_mstart (o_out.match_start)
);
